// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the encoder modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/mcme_pkg.sv =====
`default_nettype none
package mcme_pkg;

	typedef enum logic [4:0] {
		OP_NOTE_ON    = 5'd0,
		OP_NOTE_OFF   = 5'd1,
		OP_POLY_PRESS = 5'd2,
		OP_CC         = 5'd3,
		OP_PROGRAM    = 5'd4,
		OP_CHAN_PRESS = 5'd5,
		OP_BEND       = 5'd6,
		OP_RPN        = 5'd7,
		OP_NRPN       = 5'd8,
		OP_CLOCK      = 5'd9,
		OP_START      = 5'd10,
		OP_STOP       = 5'd11,
		OP_CONTINUE   = 5'd12,
		OP_SENSE      = 5'd13,
		OP_RESET      = 5'd14,
		OP_TIMECODE   = 5'd15,
		OP_SONG_POS   = 5'd16,
		OP_SONG_SEL   = 5'd17,
		OP_TUNE       = 5'd18,
		OP_MPE        = 5'd19
	} op_t;

	// Status nibbles and system bytes.
	localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
	localparam logic [3:0] ST_NOTE_ON    = 4'h9;
	localparam logic [3:0] ST_POLY_PRESS = 4'hA;
	localparam logic [3:0] ST_CC         = 4'hB;
	localparam logic [3:0] ST_PROGRAM    = 4'hC;
	localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
	localparam logic [3:0] ST_BEND       = 4'hE;

	localparam logic [7:0] SYS_TIMECODE = 8'hF1;
	localparam logic [7:0] SYS_SONG_POS = 8'hF2;
	localparam logic [7:0] SYS_SONG_SEL = 8'hF3;
	localparam logic [7:0] SYS_TUNE     = 8'hF6;
	localparam logic [7:0] SYS_CLOCK    = 8'hF8;
	localparam logic [7:0] SYS_START    = 8'hFA;
	localparam logic [7:0] SYS_CONTINUE = 8'hFB;
	localparam logic [7:0] SYS_STOP     = 8'hFC;
	localparam logic [7:0] SYS_SENSE    = 8'hFE;
	localparam logic [7:0] SYS_RESET    = 8'hFF;

	// Controller numbers used by the parameter sequences.
	localparam logic [6:0] CC_NRPN_MSB = 7'd99;
	localparam logic [6:0] CC_NRPN_LSB = 7'd98;
	localparam logic [6:0] CC_RPN_MSB  = 7'd101;
	localparam logic [6:0] CC_RPN_LSB  = 7'd100;
	localparam logic [6:0] CC_DATA_MSB = 7'd6;
	localparam logic [6:0] CC_DATA_LSB = 7'd38;
	localparam logic [6:0] DATA_NULL   = 7'h7F;
	localparam logic [13:0] RPN_PITCH_RANGE = 14'd6;

	// Number of controller messages in one parameter sequence, minus one.
	localparam logic [2:0] PARAM_LAST_MSG = 3'd5;

	// Message positions inside a parameter sequence.
	localparam logic [2:0] PM_NUM_MSB  = 3'd0;
	localparam logic [2:0] PM_NUM_LSB  = 3'd1;
	localparam logic [2:0] PM_DATA_MSB = 3'd2;
	localparam logic [2:0] PM_DATA_LSB = 3'd3;
	localparam logic [2:0] PM_NULL_MSB = 3'd4;
	localparam logic [2:0] PM_NULL_LSB = 3'd5;

	// Byte positions inside one message.
	localparam logic [1:0] POS_STATUS = 2'd0;
	localparam logic [1:0] POS_DATA1  = 2'd1;
	localparam logic [1:0] POS_DATA2  = 2'd2;

	// One classified command. For a parameter sequence d1 and d2 carry the
	// controller numbers that select the parameter.
	typedef struct packed {
		logic        is_param;
		logic [1:0]  last_pos;
		logic [7:0]  status;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [13:0] number;
		logic [13:0] value;
	} cmd_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

endpackage
`default_nettype wire

// ===== rtl/core/mcme_front.sv =====
`default_nettype none
module mcme_front (
	input  logic               start,
	input  logic               busy,
	input  logic [4:0]         operation,
	input  logic signed [31:0] first_argument,
	input  logic signed [31:0] second_argument,
	input  logic [4:0]         midi_channel,
	output logic               push,
	output mcme_pkg::cmd_t     cmd
);

	logic [6:0]  a7;
	logic [6:0]  b7;
	logic [13:0] a14;
	logic [13:0] b14;
	logic        zone_upper;
	logic [3:0]  bend_range;
	logic [3:0]  ch;
	logic        known;

	// Saturation of the signed arguments.
	always_comb begin
		if (first_argument[31])
			a7 = '0;
		else if (first_argument[30:7] != '0)
			a7 = '1;
		else
			a7 = first_argument[6:0];
		if (second_argument[31])
			b7 = '0;
		else if (second_argument[30:7] != '0)
			b7 = '1;
		else
			b7 = second_argument[6:0];
		if (first_argument[31])
			a14 = '0;
		else if (first_argument[30:14] != '0)
			a14 = '1;
		else
			a14 = first_argument[13:0];
		if (second_argument[31])
			b14 = '0;
		else if (second_argument[30:14] != '0)
			b14 = '1;
		else
			b14 = second_argument[13:0];
		if (second_argument[31])
			bend_range = '0;
		else if (second_argument[30:4] != '0)
			bend_range = '1;
		else
			bend_range = second_argument[3:0];
		zone_upper = !first_argument[31] && (first_argument[30:0] > 31'd1);
	end

	// Channel register values outside 1..16 fold onto the nearest end.
	always_comb begin
		if (midi_channel == 5'd0)
			ch = 4'd0;
		else if (midi_channel > 5'd16)
			ch = 4'd15;
		else
			ch = 4'(midi_channel - 5'd1);
	end

	always_comb begin
		known = 1'b1;
		cmd = '0;
		cmd.last_pos = mcme_pkg::POS_DATA2;
		cmd.d1 = a7;
		cmd.d2 = b7;
		unique case (mcme_pkg::op_t'(operation))
			mcme_pkg::OP_NOTE_ON:    cmd.status = {mcme_pkg::ST_NOTE_ON, ch};
			mcme_pkg::OP_NOTE_OFF:   cmd.status = {mcme_pkg::ST_NOTE_OFF, ch};
			mcme_pkg::OP_POLY_PRESS: cmd.status = {mcme_pkg::ST_POLY_PRESS, ch};
			mcme_pkg::OP_CC:         cmd.status = {mcme_pkg::ST_CC, ch};
			mcme_pkg::OP_PROGRAM: begin
				cmd.status = {mcme_pkg::ST_PROGRAM, ch};
				cmd.last_pos = mcme_pkg::POS_DATA1;
			end
			mcme_pkg::OP_CHAN_PRESS: begin
				cmd.status = {mcme_pkg::ST_CHAN_PRESS, ch};
				cmd.last_pos = mcme_pkg::POS_DATA1;
			end
			mcme_pkg::OP_BEND: begin
				cmd.status = {mcme_pkg::ST_BEND, ch};
				cmd.d1 = a14[6:0];
				cmd.d2 = a14[13:7];
			end
			mcme_pkg::OP_RPN: begin
				cmd.is_param = 1'b1;
				cmd.status = {mcme_pkg::ST_CC, ch};
				cmd.d1 = mcme_pkg::CC_RPN_MSB;
				cmd.d2 = mcme_pkg::CC_RPN_LSB;
				cmd.number = a14;
				cmd.value = b14;
			end
			mcme_pkg::OP_NRPN: begin
				cmd.is_param = 1'b1;
				cmd.status = {mcme_pkg::ST_CC, ch};
				cmd.d1 = mcme_pkg::CC_NRPN_MSB;
				cmd.d2 = mcme_pkg::CC_NRPN_LSB;
				cmd.number = a14;
				cmd.value = b14;
			end
			mcme_pkg::OP_CLOCK: begin
				cmd.status = mcme_pkg::SYS_CLOCK;
				cmd.last_pos = mcme_pkg::POS_STATUS;
			end
			mcme_pkg::OP_START: begin
				cmd.status = mcme_pkg::SYS_START;
				cmd.last_pos = mcme_pkg::POS_STATUS;
			end
			mcme_pkg::OP_STOP: begin
				cmd.status = mcme_pkg::SYS_STOP;
				cmd.last_pos = mcme_pkg::POS_STATUS;
			end
			mcme_pkg::OP_CONTINUE: begin
				cmd.status = mcme_pkg::SYS_CONTINUE;
				cmd.last_pos = mcme_pkg::POS_STATUS;
			end
			mcme_pkg::OP_SENSE: begin
				cmd.status = mcme_pkg::SYS_SENSE;
				cmd.last_pos = mcme_pkg::POS_STATUS;
			end
			mcme_pkg::OP_RESET: begin
				cmd.status = mcme_pkg::SYS_RESET;
				cmd.last_pos = mcme_pkg::POS_STATUS;
			end
			mcme_pkg::OP_TIMECODE: begin
				cmd.status = mcme_pkg::SYS_TIMECODE;
				cmd.last_pos = mcme_pkg::POS_DATA1;
				cmd.d1 = {a14[2:0], b14[3:0]};
			end
			mcme_pkg::OP_SONG_POS: begin
				cmd.status = mcme_pkg::SYS_SONG_POS;
				cmd.d1 = a14[6:0];
				cmd.d2 = a14[13:7];
			end
			mcme_pkg::OP_SONG_SEL: begin
				cmd.status = mcme_pkg::SYS_SONG_SEL;
				cmd.last_pos = mcme_pkg::POS_DATA1;
			end
			mcme_pkg::OP_TUNE: begin
				cmd.status = mcme_pkg::SYS_TUNE;
				cmd.last_pos = mcme_pkg::POS_STATUS;
			end
			mcme_pkg::OP_MPE: begin
				// Zone 1 configures on channel 1, zone 2 on channel 16.
				cmd.is_param = 1'b1;
				cmd.status = {mcme_pkg::ST_CC, zone_upper ? 4'hF : 4'h0};
				cmd.d1 = mcme_pkg::CC_RPN_MSB;
				cmd.d2 = mcme_pkg::CC_RPN_LSB;
				cmd.number = mcme_pkg::RPN_PITCH_RANGE;
				cmd.value = {3'd0, bend_range, 7'd0};
			end
			default: known = 1'b0;
		endcase
	end

	// Unknown codes produce no bytes and are dropped here.
	assign push = start && !busy && known;

endmodule
`default_nettype wire

// ===== rtl/core/mcme_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module mcme_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mcme_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output mcme_pkg::cmd_t head
);

	localparam int CNT_W = $clog2(mcme_pkg::QUEUE_DEPTH + 1);

	mcme_pkg::cmd_t                 entries_q [mcme_pkg::QUEUE_DEPTH];
	logic [mcme_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mcme_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]               count_q;

	assign full = (count_q == CNT_W'(mcme_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_cmd;
	end

	`ASSERT_NEVER(a_no_overflow, push && full, "request pushed into a full queue")
	`ASSERT_NEVER(a_no_underflow, pop && !not_empty, "request popped from an empty queue")

endmodule
`default_nettype wire

// ===== rtl/core/mcme_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module mcme_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  mcme_pkg::cmd_t head,
	output logic           pop,
	output logic           byte_valid,
	output logic [7:0]     midi_byte,
	output logic           message_start,
	output logic           last_byte
);

	mcme_pkg::cmd_t cur_q;
	logic           active_q;
	logic [2:0]     msg_q;
	logic [1:0]     pos_q;
	logic           msg_end;
	logic           cmd_end;
	logic [7:0]     byte_d;
	logic           byte_valid_q;
	logic [7:0]     midi_byte_q;
	logic           message_start_q;
	logic           last_byte_q;

	assign msg_end = (pos_q == cur_q.last_pos);
	assign cmd_end = active_q && msg_end
		&& (!cur_q.is_param || msg_q == mcme_pkg::PARAM_LAST_MSG);
	// The next request is popped in the same cycle that the last byte is selected.
	assign pop = head_valid && (!active_q || cmd_end);

	always_comb begin
		byte_d = cur_q.status;
		case (pos_q)
			mcme_pkg::POS_DATA1: begin
				byte_d = {1'b0, cur_q.d1};
				if (cur_q.is_param) begin
					case (msg_q)
						mcme_pkg::PM_NUM_MSB:  byte_d = {1'b0, cur_q.d1};
						mcme_pkg::PM_NUM_LSB:  byte_d = {1'b0, cur_q.d2};
						mcme_pkg::PM_DATA_MSB: byte_d = {1'b0, mcme_pkg::CC_DATA_MSB};
						mcme_pkg::PM_DATA_LSB: byte_d = {1'b0, mcme_pkg::CC_DATA_LSB};
						mcme_pkg::PM_NULL_MSB: byte_d = {1'b0, mcme_pkg::CC_RPN_MSB};
						mcme_pkg::PM_NULL_LSB: byte_d = {1'b0, mcme_pkg::CC_RPN_LSB};
						default:               byte_d = {1'b0, cur_q.d1};
					endcase
				end
			end
			mcme_pkg::POS_DATA2: begin
				byte_d = {1'b0, cur_q.d2};
				if (cur_q.is_param) begin
					case (msg_q)
						mcme_pkg::PM_NUM_MSB:  byte_d = {1'b0, cur_q.number[13:7]};
						mcme_pkg::PM_NUM_LSB:  byte_d = {1'b0, cur_q.number[6:0]};
						mcme_pkg::PM_DATA_MSB: byte_d = {1'b0, cur_q.value[13:7]};
						mcme_pkg::PM_DATA_LSB: byte_d = {1'b0, cur_q.value[6:0]};
						default:               byte_d = {1'b0, mcme_pkg::DATA_NULL};
					endcase
				end
			end
			default: byte_d = cur_q.status;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			msg_q <= '0;
			pos_q <= '0;
			byte_valid_q <= 1'b0;
		end else begin
			byte_valid_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				msg_q <= '0;
				pos_q <= mcme_pkg::POS_STATUS;
			end else if (cmd_end) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (msg_end) begin
					pos_q <= mcme_pkg::POS_STATUS;
					msg_q <= msg_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		midi_byte_q <= byte_d;
		message_start_q <= (pos_q == mcme_pkg::POS_STATUS);
		last_byte_q <= cmd_end;
	end

	assign byte_valid = byte_valid_q;
	assign midi_byte = midi_byte_q;
	assign message_start = message_start_q;
	assign last_byte = last_byte_q;

	`ASSERT_CLK(a_status_msb, byte_valid && message_start |-> midi_byte[7], "status byte without its top bit")
	`ASSERT_CLK(a_data_msb, byte_valid && !message_start |-> !midi_byte[7], "data byte with its top bit set")
	`ASSERT_CLK(a_contiguous, byte_valid && !last_byte |=> byte_valid, "gap inside one request's bytes")

endmodule
`default_nettype wire

// ===== rtl/core/midi_command_message_encoder_core.sv =====
// Channel   Ports                                             Handshake
// command   operation, first_argument, second_argument        start && !busy
// result    midi_byte, message_start, last_byte               byte_valid, one cycle
// config    channel_wdata                                     channel_we
//
// A request is taken on start while busy is low and waits in a two-entry queue; the
// byte sequencer then sends one byte per cycle, and a request has 1 to 18 bytes. The
// head is popped into the sequencer's request register and each byte is registered.
// Requests with unknown codes produce no bytes and are never queued.
// busy is high only while the queue is full; the receiver cannot stall.
// Reset clears the queue and the sequencer and sets the channel to 1.
`default_nettype none
module midi_command_message_encoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [4:0]         operation,
	input  logic signed [31:0] first_argument,
	input  logic signed [31:0] second_argument,
	input  logic               channel_we,
	input  logic [4:0]         channel_wdata,
	output logic               byte_valid,
	output logic [7:0]         midi_byte,
	output logic               message_start,
	output logic               last_byte
);

	logic [4:0]     midi_channel_q;
	logic           push;
	mcme_pkg::cmd_t push_cmd;
	logic           pop;
	logic           head_valid;
	mcme_pkg::cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			midi_channel_q <= 5'd1;
		else if (channel_we)
			midi_channel_q <= channel_wdata;
	end

	mcme_front u_front (
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.first_argument  (first_argument),
		.second_argument (second_argument),
		.midi_channel    (midi_channel_q),
		.push            (push),
		.cmd             (push_cmd)
	);

	mcme_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (busy),
		.not_empty (head_valid),
		.head      (head)
	);

	mcme_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.byte_valid    (byte_valid),
		.midi_byte     (midi_byte),
		.message_start (message_start),
		.last_byte     (last_byte)
	);

endmodule
`default_nettype wire
